// ----- hdl/akf_pkg.sv -----
package akf_pkg;

  localparam int unsigned NoiseW = 31;
  localparam int unsigned DataW  = 32;
  localparam int unsigned DtW    = 16;

  localparam logic [NoiseW-1:0] QAngleRst = 31'd16777;
  localparam logic [NoiseW-1:0] QBiasRst  = 31'd50332;
  localparam logic [NoiseW-1:0] RMeasRst  = 31'd503316;

  localparam logic OpUpdate = 1'b0;
  localparam logic OpSet    = 1'b1;

  localparam logic [1:0] RegQAngle = 2'd0;
  localparam logic [1:0] RegQBias  = 2'd1;
  localparam logic [1:0] RegRMeas  = 2'd2;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh7FFFFFFF;
    lo = -66'sh80000000;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ----- hdl/akf_div.sv -----
// Signed 64 by 34 bit divider, one quotient bit per cycle, truncating toward zero.
module akf_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [63:0]  num_i,
  input  logic signed [33:0]  den_i,
  output logic                busy_o,
  output logic signed [63:0]  quo_o
);
  import akf_pkg::*;

  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d;
  logic [64:0] rem_q, rem_d;
  logic [33:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [64:0] trial;

  assign busy_o = (cnt_q != 7'd0);
  assign quo_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    neg_d = neg_q;
    trial = {rem_q[63:0], quo_q[63]} - {31'd0, den_q};
    if (start_i) begin
      cnt_d = 7'd64;
      quo_d = num_i[63] ? 64'(-num_i) : 64'(num_i);
      den_d = den_i[33] ? 34'(-den_i) : 34'(den_i);
      neg_d = num_i[63] ^ den_i[33];
      rem_d = '0;
    end else if (busy_o) begin
      cnt_d = cnt_q - 7'd1;
      if (!trial[64]) begin
        rem_d = trial;
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[63:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o) else $error("divider started while busy");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> cnt_q == 7'd64) else $error("divider count not loaded");
  a_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !start_i) |=> cnt_q == $past(cnt_q) - 7'd1)
    else $error("divider count skipped");
`endif

endmodule

// ----- hdl/angle_kalman_filter_core.sv -----
// Two-state angle Kalman filter (angle and gyro bias, 2x2 covariance).
// Input channel in_valid_i/in_stall_o carries operation, new_angle, new_rate
// and dt; one transfer is accepted when valid is high and stall is low.
// Output channel out_valid_o/out_stall_i returns one angle_out per item.
// Noise registers are written over the APB port at byte addresses 0, 4 and 8.
// A set item goes straight to the output state, and an update item runs the
// update sequence first; the next item can be accepted once the sequencer is
// idle again. The update is a sequence of steps that share one 34x34 signed
// multiplier and a shifter; each of the two gain divisions waits on a
// restoring divider that yields one quotient bit per cycle. When P00 plus the
// measurement noise is zero both divisions are skipped and the gains are zero.
// The block holds stall high from acceptance until its sequencer is idle.
// The result stays in an output register until it is transferred; while the
// receiver stalls it holds, the next item may still be accepted and computed,
// and its result waits until the register is free.
// Reset clears the estimates and covariance to zero and loads the default
// noise values.
module angle_kalman_filter_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic signed [31:0]  new_angle_i,
  input  logic signed [31:0]  new_rate_i,
  input  logic [15:0]         dt_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  angle_out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import akf_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StStep  = 6'b000010,
    StDiv   = 6'b000100,
    StWait  = 6'b001000,
    StOut   = 6'b010000,
    StSetup = 6'b100000
  } state_e;

  // Step codes of the update sequence.
  typedef enum logic [4:0] {
    SRate, SAng, SDtP11, SInner, SP00, SP0110, SP11, SDiv0, SDiv1,
    SY, SA, SB, SC00, SC01, SC10, SC11, SDone
  } step_e;

  state_e state_q, state_d;
  step_e  step_q, step_d;

  logic [30:0] q_ang_q, q_bias_q, r_meas_q;
  logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [31:0] meas_q, gyro_q, rate_q, y_q, k0_q, k1_q, p00t_q, p01t_q;
  logic [15:0] dt_q;
  logic signed [33:0] dtp11_q;
  logic signed [33:0] inner_q;
  logic signed [33:0] s_q;
  logic signed [31:0] out_q;
  logic               out_v_q;
  logic               out_load;

  // Shared multiplier and shifter.
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic [4:0]         shamt;
  logic signed [67:0] shifted;
  logic               div_start, div_busy;
  logic signed [63:0] div_num, div_quo;
  logic signed [31:0] kq;
  logic               wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_comb begin
    case (paddr[3:2])
      RegQAngle: prdata = {1'b0, q_ang_q};
      RegQBias:  prdata = {1'b0, q_bias_q};
      RegRMeas:  prdata = {1'b0, r_meas_q};
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    ma    = '0;
    mb    = '0;
    shamt = 5'd16;
    case (step_q)
      SAng:   begin ma = 34'(rate_q); mb = {18'd0, dt_q}; end
      SDtP11: begin ma = 34'(p11_q); mb = {18'd0, dt_q}; end
      SP00:   begin ma = inner_q; mb = {18'd0, dt_q}; end
      SP11:   begin ma = {3'd0, q_bias_q}; mb = {18'd0, dt_q}; end
      SA:     begin ma = 34'(k0_q); mb = 34'(y_q); shamt = 5'd30; end
      SB:     begin ma = 34'(k1_q); mb = 34'(y_q); shamt = 5'd30; end
      SC00:   begin ma = 34'(k0_q); mb = 34'(p00t_q); shamt = 5'd30; end
      SC01:   begin ma = 34'(k0_q); mb = 34'(p01t_q); shamt = 5'd30; end
      SC10:   begin ma = 34'(k1_q); mb = 34'(p00t_q); shamt = 5'd30; end
      SC11:   begin ma = 34'(k1_q); mb = 34'(p01t_q); shamt = 5'd30; end
      default: ;
    endcase
  end
  assign prod    = ma * mb;
  assign shifted = prod >>> shamt;

  assign div_num = (step_q == SDiv0) ? (64'(p00_q) <<< 30) : (64'(p10_q) <<< 30);
  assign div_start = (state_q == StStep) && (step_q == SDiv0 || step_q == SDiv1)
                     && (s_q != 34'sd0);
  assign kq = sat32(66'(div_quo));

  akf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (s_q),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  // A finished item moves into the output register once it is empty or its
  // current result is transferred in this cycle.
  assign out_load    = (state_q == StOut) && (!out_v_q || !out_stall_i);
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_v_q;
  assign angle_out_o = out_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      StIdle:  if (in_valid_i && !in_stall_o) begin
        state_d = (operation_i == OpSet) ? StOut : StSetup;
        step_d  = SRate;
      end
      StSetup: state_d = StStep;
      StStep: begin
        if (step_q == SDone) begin
          state_d = StOut;
        end else if ((step_q == SDiv0 || step_q == SDiv1) && s_q != 34'sd0) begin
          state_d = StDiv;
        end else begin
          step_d = step_e'(step_q + 5'd1);
        end
      end
      StDiv:   state_d = StWait;
      StWait:  if (!div_busy) begin
        state_d = StStep;
        step_d  = step_e'(step_q + 5'd1);
      end
      StOut:   if (out_load) begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      step_q   <= SRate;
      out_v_q  <= 1'b0;
      q_ang_q  <= QAngleRst;
      q_bias_q <= QBiasRst;
      r_meas_q <= RMeasRst;
      ang_q <= '0; bias_q <= '0;
      p00_q <= '0; p01_q <= '0; p10_q <= '0; p11_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (wr) begin
        case (paddr[3:2])
          RegQAngle: q_ang_q  <= pwdata[30:0];
          RegQBias:  q_bias_q <= pwdata[30:0];
          RegRMeas:  r_meas_q <= pwdata[30:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (state_q == StIdle && in_valid_i && !in_stall_o && operation_i == OpSet) begin
        ang_q <= new_angle_i;
      end
      if (state_q == StStep) begin
        case (step_q)
          SRate:  rate_q <= sat32(66'(gyro_q) - 66'(bias_q));
          SAng:   ang_q <= sat32(66'(ang_q) + 66'(shifted));
          SDtP11: dtp11_q <= 34'(shifted);
          SInner: inner_q <= dtp11_q - 34'(p01_q) - 34'(p10_q) + 34'({1'b0, q_ang_q});
          SP00:   p00_q <= sat32(66'(p00_q) + 66'(shifted));
          SP0110: begin
            p01_q <= sat32(66'(p01_q) - 66'(dtp11_q));
            p10_q <= sat32(66'(p10_q) - 66'(dtp11_q));
          end
          SP11: begin
            p11_q <= sat32(66'(p11_q) + 66'(shifted));
            s_q   <= 34'(sat32(66'(p00_q))) + 34'({1'b0, r_meas_q});
          end
          SDiv0:  k0_q <= '0;
          SDiv1:  k1_q <= '0;
          SY: begin
            y_q    <= sat32(66'(meas_q) - 66'(ang_q));
            p00t_q <= p00_q;
            p01t_q <= p01_q;
          end
          SA:   ang_q  <= sat32(66'(ang_q) - 66'(0) + 66'(shifted));
          SB:   bias_q <= sat32(66'(bias_q) + 66'(shifted));
          SC00: p00_q  <= sat32(66'(p00_q) - 66'(shifted));
          SC01: p01_q  <= sat32(66'(p01_q) - 66'(shifted));
          SC10: p10_q  <= sat32(66'(p10_q) - 66'(shifted));
          SC11: p11_q  <= sat32(66'(p11_q) - 66'(shifted));
          default: ;
        endcase
      end
      if (state_q == StWait && !div_busy) begin
        if (step_q == SDiv0) k0_q <= kq;
        else k1_q <= kq;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i && !in_stall_o) begin
      meas_q <= new_angle_i;
      gyro_q <= new_rate_i;
      dt_q   <= dt_i;
    end
    if (out_load) out_q <= ang_q;
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(angle_out_o)))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("ready while busy");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == StWait || state_q == StDiv))
    else $error("divider busy outside wait");
`endif

endmodule
